FILE: design/stuffed_word_frame_decoder_macros.svh
// assertion helpers for the stuffed word frame decoder checker
`ifndef STUFFED_WORD_FRAME_DECODER_MACROS_SVH
`define STUFFED_WORD_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SWFD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swfd assertion failed");

// next-cycle implication, disabled while in reset
`define SWFD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swfd assertion failed");

`endif

FILE: design/swfd_pkg.sv
// ----------------------------------------------------------------------------
// swfd_pkg
// shared types and constants of the stuffed word frame decoder
// ----------------------------------------------------------------------------
package swfd_pkg;

    localparam int WORD_BYTES_DEF = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [7:0] HEAD_RST   = 8'd126;
    localparam logic [7:0] ESCAPE_RST = 8'd125;
    localparam logic [7:0] MASK_RST   = 8'd32;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_INDEX = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_HEAD   = 2'd0,
        REG_ESCAPE = 2'd1,
        REG_MASK   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] escape;
        logic [7:0] mask;
    } cfg_t;

    typedef struct packed {
        logic        fire;
        logic [7:0]  index;
        logic [31:0] word;
        logic        ok;
    } result_t;

endpackage

FILE: design/stuffed_word_frame_decoder.sv
// ----------------------------------------------------------------------------
// stuffed_word_frame_decoder
// byte-stuffed frame receiver: head, index, escaped data word, sum checksum
// ----------------------------------------------------------------------------
// a checksum beat shows its result after passing the input register and then the result register
// throughput: one byte beat per cycle unless a result beat is blocked, set by the single input register stage
// a result beat waiting on out_stall holds one more byte in the input register
// reset: async active low, decoder idle, registers at 126 / 125 / 32
module stuffed_word_frame_decoder #(
    parameter int WORD_BYTES = swfd_pkg::WORD_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swfd_pkg::APB_AW-1:0] paddr,
    input  logic [swfd_pkg::APB_DW-1:0] pwdata,
    output logic [swfd_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // received byte channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  rx_byte,
    // decoded frame channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  target_index,
    output logic signed [31:0]          word_value,
    output logic                        frame_ok
);

    swfd_pkg::cfg_t    cfg;
    swfd_pkg::result_t result;

    // input register stage
    logic       in_full_reg, in_full_next;
    logic [7:0] byte_reg;
    logic       in_take;
    logic       advance;

    // result register stage
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        index_out_reg;
    logic signed [31:0] word_out_reg;
    logic              ok_out_reg;

    swfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held byte moves on unless a finished result is still blocked
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
    end

    swfd_frame_core #(
        .WORD_BYTES (WORD_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // result beat: load on the checksum byte, drop once taken
    always_comb
    begin
        if (result.fire)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.fire)
        begin
            index_out_reg <= result.index;
            word_out_reg  <= signed'(result.word);
            ok_out_reg    <= result.ok;
        end
    end

    assign out_valid    = out_valid_reg;
    assign target_index = index_out_reg;
    assign word_value   = word_out_reg;
    assign frame_ok     = ok_out_reg;

endmodule

FILE: design/swfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// swfd_cfg_regs
// apb register file: head, escape and mask byte values
// ----------------------------------------------------------------------------
module swfd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swfd_pkg::APB_AW-1:0]   paddr,
    input  logic [swfd_pkg::APB_DW-1:0]   pwdata,
    output logic [swfd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output swfd_pkg::cfg_t                cfg
);

    swfd_pkg::cfg_t     cfg_reg;
    swfd_pkg::reg_idx_t sel_idx;
    logic               wr_en;
    logic [7:0]         rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign sel_idx = swfd_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head   <= swfd_pkg::HEAD_RST;
            cfg_reg.escape <= swfd_pkg::ESCAPE_RST;
            cfg_reg.mask   <= swfd_pkg::MASK_RST;
        end
        else if (wr_en)
        begin
            case (sel_idx)
                swfd_pkg::REG_HEAD:   cfg_reg.head   <= pwdata[7:0];
                swfd_pkg::REG_ESCAPE: cfg_reg.escape <= pwdata[7:0];
                swfd_pkg::REG_MASK:   cfg_reg.mask   <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (sel_idx)
            swfd_pkg::REG_HEAD:   rd_byte = cfg_reg.head;
            swfd_pkg::REG_ESCAPE: rd_byte = cfg_reg.escape;
            swfd_pkg::REG_MASK:   rd_byte = cfg_reg.mask;
            default:              rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(swfd_pkg::APB_DW-8){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

endmodule

FILE: design/swfd_frame_core.sv
// ----------------------------------------------------------------------------
// swfd_frame_core
// frame state machine, unstuffing, checksum and word assembly
// ----------------------------------------------------------------------------
module swfd_frame_core #(
    parameter int WORD_BYTES = swfd_pkg::WORD_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  swfd_pkg::cfg_t    cfg,
    output swfd_pkg::result_t result
);

    localparam int CNT_W = $clog2(WORD_BYTES + 1);

    swfd_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             esc_reg, esc_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      word_reg, word_next;
    logic [7:0]       index_reg, index_next;

    logic       take;
    logic       last;
    logic [7:0] data_b;

    // a data byte is stored unless it is a fresh escape marker
    assign take   = esc_reg || (rx_byte != cfg.escape);
    assign last   = (count_reg == CNT_W'(WORD_BYTES - 1));
    assign data_b = esc_reg ? (rx_byte ^ cfg.mask) : rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                swfd_pkg::PH_IDLE:
                    if (rx_byte == cfg.head)
                        phase_next = swfd_pkg::PH_INDEX;
                swfd_pkg::PH_INDEX:
                    phase_next = swfd_pkg::PH_DATA;
                swfd_pkg::PH_DATA:
                    if (take && last)
                        phase_next = swfd_pkg::PH_CHECK;
                swfd_pkg::PH_CHECK:
                    phase_next = swfd_pkg::PH_IDLE;
                default:
                    phase_next = swfd_pkg::PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        esc_next   = esc_reg;
        sum_next   = sum_reg;
        word_next  = word_reg;
        index_next = index_reg;
        if (step)
        begin
            case (phase_reg)
                swfd_pkg::PH_IDLE:
                    if (rx_byte == cfg.head)
                    begin
                        count_next = '0;
                        esc_next   = 1'b0;
                        sum_next   = 8'd0;
                        word_next  = 32'd0;
                    end
                swfd_pkg::PH_INDEX:
                    index_next = rx_byte;
                swfd_pkg::PH_DATA:
                begin
                    sum_next = sum_reg + rx_byte;
                    esc_next = !esc_reg && (rx_byte == cfg.escape);
                    if (take)
                    begin
                        word_next  = {word_reg[23:0], data_b};
                        count_next = count_reg + 1'b1;
                    end
                end
                swfd_pkg::PH_CHECK:
                begin
                    count_next = '0;
                    esc_next   = 1'b0;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= swfd_pkg::PH_IDLE;
            count_reg <= '0;
            esc_reg   <= 1'b0;
            sum_reg   <= 8'd0;
            word_reg  <= 32'd0;
            index_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            esc_reg   <= esc_next;
            sum_reg   <= sum_next;
            word_reg  <= word_next;
            index_reg <= index_next;
        end
    end

    assign result.fire  = step && (phase_reg == swfd_pkg::PH_CHECK);
    assign result.index = index_reg;
    assign result.word  = word_reg;
    assign result.ok    = (sum_reg == rx_byte);

endmodule

FILE: design/swfd_checker.sv
// ----------------------------------------------------------------------------
// swfd_checker
// port-level checks of the stuffed word frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "stuffed_word_frame_decoder_macros.svh"

module swfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         target_index,
    input logic signed [31:0] word_value,
    input logic               frame_ok
);

    // a blocked result beat keeps its payload
    `SWFD_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(word_value) && $stable(target_index) && $stable(frame_ok))

    // the input side only backs up behind a blocked result
    `SWFD_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // a fresh result follows a byte beat that was taken and went through the input register
    `SWFD_ASSERT_IMP(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind stuffed_word_frame_decoder swfd_checker u_swfd_checker (.*);

FILE: tb/stuffed_word_frame_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_word_frame_decoder_checker
// follows the config port and the byte channel, predicts every decoded frame
// and compares each result beat with the oldest frame still due
// ----------------------------------------------------------------------------
module stuffed_word_frame_decoder_checker
    import swfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        target_index,
    input  logic [31:0]       word_value,
    input  logic              frame_ok,
    output int                mismatches,
    output int                frames_due
);

    typedef struct packed {
        logic [7:0]  index;
        logic [31:0] word;
        logic        ok;
    } frame_t;

    cfg_t        cfg;
    phase_t      dec_phase;
    int          data_count;
    logic        escape_armed;
    logic [7:0]  sum;
    logic [31:0] word_acc;
    logic [7:0]  index_acc;
    frame_t      due_q[$];

    task automatic flag(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ERROR %s", $time, what);
    endtask

    // one received byte through the frame decoder
    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] data;
        case (dec_phase)
            PH_IDLE:
            begin
                if (b == cfg.head)
                begin
                    dec_phase    = PH_INDEX;
                    data_count   = 0;
                    escape_armed = 1'b0;
                    sum          = 8'h00;
                    word_acc     = 32'h0;
                end
            end
            PH_INDEX:
            begin
                index_acc = b;
                dec_phase = PH_DATA;
            end
            PH_DATA:
            begin
                sum = sum + b;
                if (!escape_armed && b == cfg.escape)
                    escape_armed = 1'b1;
                else
                begin
                    data         = escape_armed ? (b ^ cfg.mask) : b;
                    escape_armed = 1'b0;
                    word_acc     = {word_acc[23:0], data};
                    data_count++;
                    if (data_count >= WORD_BYTES_DEF)
                        dec_phase = PH_CHECK;
                end
            end
            default:
            begin
                due_q.push_back('{index: index_acc, word: word_acc, ok: (sum == b)});
                dec_phase    = PH_IDLE;
                data_count   = 0;
                escape_armed = 1'b0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            cfg          = '{head: HEAD_RST, escape: ESCAPE_RST, mask: MASK_RST};
            dec_phase    = PH_IDLE;
            data_count   = 0;
            escape_armed = 1'b0;
            sum          = 8'h00;
            word_acc     = 32'h0;
            index_acc    = 8'h00;
            mismatches   = 0;
            due_q.delete();
            frames_due  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_q.size() == 0)
                    flag($sformatf("unexpected frame: index %02h word %08h ok %0b",
                                   target_index, word_value, frame_ok));
                else
                begin
                    want = due_q.pop_front();
                    if (target_index !== want.index || word_value !== want.word ||
                        frame_ok !== want.ok)
                        flag($sformatf({"frame mismatch: expected index %02h word %08h ok %0b,",
                                        " got index %02h word %08h ok %0b"},
                                       want.index, want.word, want.ok,
                                       target_index, word_value, frame_ok));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_HEAD:   cfg.head   = pwdata[7:0];
                    REG_ESCAPE: cfg.escape = pwdata[7:0];
                    REG_MASK:   cfg.mask   = pwdata[7:0];
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
                decode_byte(rx_byte);
            frames_due <= due_q.size();
        end
    end

endmodule

FILE: tb/stuffed_word_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_word_frame_decoder_tb
// drives byte-stuffed frames, stray bytes and broken frames into the decoder
// under four register settings and four idle patterns; a checker beside the
// decoder predicts and compares every decoded frame
// ----------------------------------------------------------------------------
module stuffed_word_frame_decoder_tb;
    import swfd_pkg::*;

    localparam int BEATS_PER_PHASE = 100;
    localparam int QUIET_LIMIT     = 2000;
    // let the decoder's input and result registers drain before a config write
    localparam int SETTLE_CYCLES   = 8;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte   = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        target_index;
    logic signed [31:0] word_value;
    logic              frame_ok;

    int   mismatches;
    int   frames_due;
    int   src_idle_pct  = 0;
    int   dst_stall_pct = 0;
    int   beats_sent    = 0;
    int   quiet_cycles  = 0;
    // register values as last written, used to encode frames
    cfg_t cur_cfg = '{head: HEAD_RST, escape: ESCAPE_RST, mask: MASK_RST};

    stuffed_word_frame_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_index (target_index),
        .word_value   (word_value),
        .frame_ok     (frame_ok)
    );

    stuffed_word_frame_decoder_checker frame_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_index (target_index),
        .word_value   (word_value),
        .frame_ok     (frame_ok),
        .mismatches   (mismatches),
        .frames_due   (frames_due)
    );

    always #5 clk = ~clk;

    // receiver side: random stall at the rate of the current phase
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < dst_stall_pct);

    // watchdog: cycles with no beat on any channel and no config access
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one byte beat, with random idle cycles ahead of it
    // called at a clock edge, returns at the edge that accepted the beat
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // head, raw index, stuffed data word msb first, then the sum checksum
    // a good frame carries the right sum, a bad one a corrupted sum
    task automatic send_frame(input logic [7:0] idx, input logic [31:0] word, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        send_byte(cur_cfg.head);
        send_byte(idx);
        for (int k = 3; k >= 0; k--)
        begin
            b = word[8*k +: 8];
            // escape bytes must be stuffed, other bytes now and then too
            if (b == cur_cfg.escape || $urandom_range(7) == 0)
            begin
                send_byte(cur_cfg.escape);
                send_byte(b ^ cur_cfg.mask);
                sum = sum + cur_cfg.escape + (b ^ cur_cfg.mask);
            end
            else
            begin
                send_byte(b);
                sum = sum + b;
            end
        end
        send_byte(good ? sum : (sum ^ 8'($urandom_range(255, 1))));
    endtask

    // setup and access cycle, write lands at the edge with pready high
    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEAD:   cur_cfg.head   = val;
            REG_ESCAPE: cur_cfg.escape = val;
            REG_MASK:   cur_cfg.mask   = val;
            default:    ;
        endcase
    endtask

    // sender holds off until every due frame is out and the decoder is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_t        setting;
        int          phase_end;
        int          pick;
        logic [31:0] word;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, registers at their reset values
        // stray byte outside a frame is dropped
        send_byte(8'hFF);
        // escape byte as index is raw, masked data byte, escape after escape,
        // head byte as data, escape byte as checksum
        send_byte(HEAD_RST);
        send_byte(ESCAPE_RST);
        send_byte(ESCAPE_RST);
        send_byte(8'h5E);
        send_byte(ESCAPE_RST);
        send_byte(ESCAPE_RST);
        send_byte(HEAD_RST);
        send_byte(8'h80);
        send_byte(ESCAPE_RST);
        // head byte as index and as checksum, all-zero word, bad sum
        send_byte(HEAD_RST);
        send_byte(HEAD_RST);
        repeat (4) send_byte(8'h00);
        send_byte(HEAD_RST);
        // field extremes, one good and one bad checksum
        send_frame(8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_frame(8'h00, 32'h8000_0000, 1'b0);

        // random part: four register settings, four idle patterns
        for (int p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    setting       = '{head: 8'h00, escape: 8'hFF, mask: 8'hFF};
                    src_idle_pct  = 0;
                    dst_stall_pct = 0;
                end
                1:
                begin
                    setting       = '{head: 8'hFF, escape: 8'h00, mask: 8'h00};
                    src_idle_pct  = 52;
                    dst_stall_pct = 0;
                end
                2:
                begin
                    setting       = '{head: 8'($urandom), escape: 8'($urandom),
                                      mask: 8'($urandom)};
                    src_idle_pct  = 0;
                    dst_stall_pct = 52;
                end
                default:
                begin
                    setting       = '{head: HEAD_RST, escape: ESCAPE_RST, mask: MASK_RST};
                    src_idle_pct  = 36;
                    dst_stall_pct = 36;
                end
            endcase
            write_reg(REG_HEAD, setting.head);
            write_reg(REG_ESCAPE, setting.escape);
            write_reg(REG_MASK, setting.mask);

            phase_end = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(99);
                word = $urandom;
                // seed the word with head and escape values now and then
                for (int k = 0; k < 4; k++)
                    if ($urandom_range(3) == 0)
                        word[8*k +: 8] = $urandom_range(1) ? cur_cfg.head : cur_cfg.escape;
                if (pick < 80)
                    send_frame(($urandom_range(3) == 0) ? cur_cfg.escape : 8'($urandom),
                               word, $urandom_range(3) != 0);
                else if (pick < 90)
                    // stray byte, may start a frame if it matches the head
                    send_byte(8'($urandom));
                else
                begin
                    // cut-off frame, the bytes after it are taken into it
                    send_byte(cur_cfg.head);
                    repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: stuffed_word_frame_decoder.f
+incdir+design
design/swfd_pkg.sv
design/swfd_cfg_regs.sv
design/swfd_frame_core.sv
design/stuffed_word_frame_decoder.sv
design/swfd_checker.sv
tb/stuffed_word_frame_decoder_checker.sv
tb/stuffed_word_frame_decoder_tb.sv
